// ===== rtl/vertex_weld_table_unit_assert.svh =====
`ifndef VERTEX_WELD_TABLE_UNIT_ASSERT_SVH
`define VERTEX_WELD_TABLE_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define VWT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define VWT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vwt_pkg.sv =====
package vwt_pkg;

    localparam int MODE_BITS   = 2;
    localparam int INDEX_BITS  = 10;
    localparam int THRESH_BITS = 23;
    localparam int FLAG_BITS   = 3;
    localparam int ADDR_BITS   = 2;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_FIND       = 2'd0,
        MODE_ADD_MISS   = 2'd1,
        MODE_ADD_ALWAYS = 2'd2,
        MODE_UNUSED     = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    localparam logic [ADDR_BITS-1:0] REG_THRESHOLD_ADDR = 2'd0;

    localparam int FLAG_FOUND = 0;
    localparam int FLAG_ADDED = 1;
    localparam int FLAG_FULL  = 2;

endpackage

// ===== rtl/vertex_weld_table_unit.sv =====
// Vertex weld point table. Each request carries a point and a mode; every mode
// but add-always, on a non-empty table, scans every stored point, one per cycle
// out of the point store's read port, through a four-stage distance pipeline.
// Add-always requests and requests on an empty table skip the scan. A result
// that is not taken holds the block in its finish step. One request is worked
// at a time; a new one is taken as soon as the previous result sits in the
// output register. The nearest stored point with squared distance below
// threshold squared wins, ties going to the lowest index. The point store is
// not cleared after reset.
module vertex_weld_table_unit #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // request channel
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // pos_x, pos_y, pos_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]           s_tdata,
    // mode
    input  logic [vwt_pkg::MODE_BITS-1:0]               s_tuser,
    // result channel
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // weld_idx, min_x, min_y, min_z, max_x, max_y, max_z
    output logic [((vwt_pkg::INDEX_BITS+6*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // found, added, table_full
    output logic [vwt_pkg::FLAG_BITS-1:0]               m_tuser,
    // configuration
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [vwt_pkg::ADDR_BITS-1:0]               paddr,
    input  logic [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);
    import vwt_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int SQ_W     = 2 * (C + 1);
    localparam int SUM_W    = SQ_W + 2;
    localparam int TSQ_W    = 2 * THRESH_BITS;
    localparam int BEST_W   = (SUM_W > TSQ_W) ? SUM_W : TSQ_W;
    localparam int M_DATA_W = ((INDEX_BITS + 6 * C + 7) / 8) * 8;

    localparam logic signed [C-1:0] COORD_MAX = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] COORD_MIN = {1'b1, {(C-1){1'b0}}};

    // configuration
    logic [THRESH_BITS-1:0] thr_reg;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_THRESHOLD_ADDR);
    assign prdata = (paddr == REG_THRESHOLD_ADDR) ? 32'(thr_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_wr) begin
            thr_reg <= pwdata[THRESH_BITS-1:0];
        end
    end

    // control and request state
    state_t                 state_reg, state_next;
    mode_t                  mode_reg;
    logic signed [C-1:0]    pos_reg [3];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       scan_addr_reg;
    logic [BEST_W-1:0]      best_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic                   hit_reg;
    logic signed [C-1:0]    box_min_reg [3];
    logic signed [C-1:0]    box_max_reg [3];

    // distance pipeline
    logic                   p0_valid_reg, p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [IDX_W-1:0]       p0_idx_reg, p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic [C:0]             p1_abs_reg [3];
    logic [SQ_W-1:0]        p2_sq_reg [3];
    logic [SUM_W-1:0]       p3_sum_reg;

    // point store
    logic [3*C-1:0]         store_mem [MAX_POINTS];
    logic [3*C-1:0]         rd_data_reg;
    logic                   rd_en;
    logic                   wr_en;

    // output register
    logic                   m_valid_reg;
    logic [M_DATA_W-1:0]    m_data_reg;
    logic [FLAG_BITS-1:0]   m_user_reg;

    // request accept and finish decisions
    logic                   s_accept;
    logic                   out_free;
    logic                   fin_load;
    logic                   want_add;
    logic                   is_full;
    logic                   scan_last;
    logic                   pipe_busy;
    logic [BEST_W-1:0]      thr_sq;
    logic [BEST_W-1:0]      cand;
    logic                   cand_better;
    logic [IDX_W-1:0]       res_idx;
    logic [INDEX_BITS+IDX_W-1:0] res_idx_wide;
    logic signed [C-1:0]    box_min_new [3];
    logic signed [C-1:0]    box_max_new [3];
    logic [3*C-1:0]         pos_packed;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign fin_load  = (state_reg == ST_FIN) && out_free;
    assign is_full   = (count_reg == CNT_W'(MAX_POINTS));
    assign want_add  = (mode_reg == MODE_ADD_ALWAYS) ||
                       ((mode_reg == MODE_ADD_MISS) && !hit_reg);
    assign wr_en     = fin_load && want_add && !is_full;
    assign rd_en     = (state_reg == ST_SCAN);
    assign scan_last = (scan_addr_reg == count_reg - CNT_W'(1));
    assign pipe_busy = p0_valid_reg || p1_valid_reg || p2_valid_reg || p3_valid_reg;
    assign thr_sq    = BEST_W'(thr_reg) * BEST_W'(thr_reg);
    assign cand      = BEST_W'(p3_sum_reg);
    assign cand_better = p3_valid_reg && (cand < best_reg);
    assign pos_packed  = {pos_reg[2], pos_reg[1], pos_reg[0]};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if ((mode_t'(s_tuser) != MODE_ADD_ALWAYS) && (count_reg != '0)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request capture and best-match tracking
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg   <= mode_t'(s_tuser);
            pos_reg[0] <= s_tdata[C-1:0];
            pos_reg[1] <= s_tdata[2*C-1:C];
            pos_reg[2] <= s_tdata[3*C-1:2*C];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (s_accept) begin
            hit_reg <= 1'b0;
        end else if (cand_better) begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            best_reg     <= thr_sq;
            best_idx_reg <= '0;
        end else if (cand_better) begin
            best_reg     <= cand;
            best_idx_reg <= p3_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg <= '0;
        end else if (s_accept) begin
            scan_addr_reg <= '0;
        end else if (rd_en) begin
            scan_addr_reg <= scan_addr_reg + CNT_W'(1);
        end
    end

    // point store, one port each way, read data registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[count_reg[IDX_W-1:0]] <= pos_packed;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[scan_addr_reg[IDX_W-1:0]];
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p0_valid_reg <= rd_en;
            p1_valid_reg <= p0_valid_reg;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // absolute differences, squares, sum
    always_ff @(posedge aclk) begin
        logic signed [C:0] diff;
        p0_idx_reg <= scan_addr_reg[IDX_W-1:0];
        p1_idx_reg <= p0_idx_reg;
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        for (int k = 0; k < 3; k++) begin
            diff = {pos_reg[k][C-1], pos_reg[k]} -
                   {rd_data_reg[k*C+C-1], rd_data_reg[k*C +: C]};
            p1_abs_reg[k] <= diff[C] ? (C+1)'(-diff) : (C+1)'(diff);
            p2_sq_reg[k]  <= SQ_W'(p1_abs_reg[k]) * SQ_W'(p1_abs_reg[k]);
        end
        p3_sum_reg <= SUM_W'(p2_sq_reg[0]) + SUM_W'(p2_sq_reg[1]) + SUM_W'(p2_sq_reg[2]);
    end

    // bounding box and count
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            box_min_new[k] = box_min_reg[k];
            box_max_new[k] = box_max_reg[k];
            if (wr_en && (pos_reg[k] < box_min_reg[k])) begin
                box_min_new[k] = pos_reg[k];
            end
            if (wr_en && (pos_reg[k] > box_max_reg[k])) begin
                box_max_new[k] = pos_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                box_min_reg[k] <= COORD_MAX;
                box_max_reg[k] <= COORD_MIN;
            end
        end else if (wr_en) begin
            count_reg <= count_reg + CNT_W'(1);
            for (int k = 0; k < 3; k++) begin
                box_min_reg[k] <= box_min_new[k];
                box_max_reg[k] <= box_max_new[k];
            end
        end
    end

    // result
    always_comb begin
        priority if (want_add && is_full) begin
            res_idx = '0;
        end else if (want_add) begin
            res_idx = count_reg[IDX_W-1:0];
        end else if (hit_reg) begin
            res_idx = best_idx_reg;
        end else begin
            res_idx = '0;
        end
    end

    assign res_idx_wide = {{INDEX_BITS{1'b0}}, res_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            m_data_reg <= M_DATA_W'({box_max_new[2], box_max_new[1], box_max_new[0],
                                     box_min_new[2], box_min_new[1], box_min_new[0],
                                     res_idx_wide[INDEX_BITS-1:0]});
            m_user_reg[FLAG_FOUND] <= (mode_reg != MODE_ADD_ALWAYS) && hit_reg;
            m_user_reg[FLAG_ADDED] <= want_add && !is_full;
            m_user_reg[FLAG_FULL]  <= want_add && is_full;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`include "vertex_weld_table_unit_assert.svh"

    `VWT_ASSERT_SAME(a_count_range, aclk, aresetn, 1'b1,
        count_reg <= CNT_W'(MAX_POINTS), "point count above table size")
    `VWT_ASSERT_SAME(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN,
        scan_addr_reg < count_reg, "scan reads past stored points")
    `VWT_ASSERT_SAME(a_pipe_in_scan, aclk, aresetn, p3_valid_reg,
        state_reg == ST_SCAN || state_reg == ST_DRAIN, "distance result outside scan")
    `VWT_ASSERT_SAME(a_flags_exclusive, aclk, aresetn, m_valid_reg,
        $countones(m_user_reg) <= 1, "result flags overlap")
    `VWT_ASSERT_NEXT(a_count_step, aclk, aresetn, wr_en,
        count_reg == $past(count_reg) + CNT_W'(1), "count did not follow an append")

endmodule

// ===== tb/sv/vertex_weld_table_unit_test.sv =====
typedef struct packed {
    logic [9:0]         pidx;
    logic               found;
    logic               added;
    logic               full;
    logic signed [23:0] lo_x;
    logic signed [23:0] lo_y;
    logic signed [23:0] lo_z;
    logic signed [23:0] hi_x;
    logic signed [23:0] hi_y;
    logic signed [23:0] hi_z;
} weld_result_t;

class weld_scoreboard;
    localparam int DEPTH = 1024;

    logic signed [23:0] stored [DEPTH][3];
    int                 point_total;
    logic [22:0]        match_limit;
    logic signed [23:0] box_lo [3];
    logic signed [23:0] box_hi [3];
    weld_result_t       awaited_results [$];
    int                 errors;
    int                 n_req;
    int                 n_found;
    int                 n_added;
    int                 n_full;

    function new();
        point_total = 0;
        match_limit = '0;
        for (int k = 0; k < 3; k++) begin
            box_lo[k] = 24'sh7FFFFF;
            box_hi[k] = 24'sh800000;
        end
        errors = 0;
        n_req = 0;
        n_found = 0;
        n_added = 0;
        n_full = 0;
    endfunction

    function void set_threshold(logic [22:0] t);
        match_limit = t;
    endfunction

    task report(string what);
        errors++;
        if (errors <= 30)
            $display("mismatch: %s", what);
    endtask

    // nearest stored point below threshold, then append as the mode asks
    task note_request(vwt_pkg::mode_t m, logic signed [23:0] x, logic signed [23:0] y,
                      logic signed [23:0] z);
        weld_result_t       r;
        logic signed [23:0] p [3];
        longint             best;
        longint             d;
        longint             dv;
        logic               want_add;

        r = '0;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        want_add = 1'b0;
        n_req++;
        if (m != vwt_pkg::MODE_ADD_ALWAYS) begin
            best = longint'(match_limit) * longint'(match_limit);
            for (int i = 0; i < point_total; i++) begin
                d = 0;
                for (int k = 0; k < 3; k++) begin
                    dv = longint'(p[k]) - longint'(stored[i][k]);
                    d = d + dv * dv;
                end
                if (d < best) begin
                    best = d;
                    r.pidx = i[9:0];
                    r.found = 1'b1;
                end
            end
            if (!r.found && m == vwt_pkg::MODE_ADD_MISS)
                want_add = 1'b1;
        end else begin
            want_add = 1'b1;
        end
        if (want_add) begin
            if (point_total >= DEPTH) begin
                r.full = 1'b1;
                r.pidx = '0;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    stored[point_total][k] = p[k];
                    if (box_lo[k] > p[k])
                        box_lo[k] = p[k];
                    if (box_hi[k] < p[k])
                        box_hi[k] = p[k];
                end
                r.pidx = point_total[9:0];
                point_total++;
                r.added = 1'b1;
            end
        end
        r.lo_x = box_lo[0];
        r.lo_y = box_lo[1];
        r.lo_z = box_lo[2];
        r.hi_x = box_hi[0];
        r.hi_y = box_hi[1];
        r.hi_z = box_hi[2];
        if (r.found)
            n_found++;
        if (r.added)
            n_added++;
        if (r.full)
            n_full++;
        awaited_results.push_back(r);
    endtask

    task cmp_field(string name, logic [23:0] got, logic [23:0] want);
        if (got !== want)
            report($sformatf("request %0d field %s got %0h want %0h",
                             n_req - awaited_results.size() - 1, name, got, want));
    endtask

    task check_result(logic [159:0] data, logic [2:0] flags);
        weld_result_t e;
        if (awaited_results.size() == 0) begin
            report("result with no request waiting");
            return;
        end
        e = awaited_results.pop_front();
        cmp_field("weld_idx", 24'(data[9:0]), 24'(e.pidx));
        cmp_field("found", 24'(flags[vwt_pkg::FLAG_FOUND]), 24'(e.found));
        cmp_field("added", 24'(flags[vwt_pkg::FLAG_ADDED]), 24'(e.added));
        cmp_field("table_full", 24'(flags[vwt_pkg::FLAG_FULL]), 24'(e.full));
        cmp_field("min_x", data[33:10], e.lo_x);
        cmp_field("min_y", data[57:34], e.lo_y);
        cmp_field("min_z", data[81:58], e.lo_z);
        cmp_field("max_x", data[105:82], e.hi_x);
        cmp_field("max_y", data[129:106], e.hi_y);
        cmp_field("max_z", data[153:130], e.hi_z);
    endtask
endclass

module vertex_weld_table_unit_test;
    import vwt_pkg::*;

    localparam int S_W = ((3 * 24 + 7) / 8) * 8;
    localparam int M_W = ((INDEX_BITS + 6 * 24 + 7) / 8) * 8;
    localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] C_MIN = 24'sh800000;
    localparam logic [22:0] THRESH_TOP = 23'h7FFFFF;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata;
    logic [MODE_BITS-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_W-1:0]         m_tdata;
    logic [FLAG_BITS-1:0]   m_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_BITS-1:0]   paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    bit                     no_idle = 1'b0;
    weld_scoreboard         sb;

    vertex_weld_table_unit #(
        .MAX_POINTS(1024),
        .COORD_BITS(24)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #400000000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= no_idle || ($urandom_range(99) >= 38);
    end

    function automatic logic signed [23:0] clamp_coord(longint v);
        if (v > 64'sd8388607)
            return C_MAX;
        if (v < -64'sd8388608)
            return C_MIN;
        return v[23:0];
    endfunction

    function automatic logic signed [23:0] rand_coord();
        int unsigned r;
        logic [31:0] w;
        r = $urandom_range(99);
        w = $urandom();
        if (r < 30)
            return w[23:0];
        if (r < 60)
            return clamp_coord(longint'($urandom_range(4096)) - 2048);
        if (r < 80)
            return clamp_coord(longint'($urandom_range(131072)) - 65536);
        case ($urandom_range(3))
            0: return C_MAX;
            1: return C_MIN;
            2: return 24'sd0;
            default: return -24'sd1;
        endcase
    endfunction

    function automatic int unsigned pick_spread(logic [22:0] thr);
        if (thr == 0)
            return $urandom_range(3);
        case ($urandom_range(3))
            0: return 0;
            1: return thr / 4;
            2: return thr / 2;
            default: return thr;
        endcase
    endfunction

    task automatic send_point(mode_t m, logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [23:0] z);
        while (!no_idle && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        s_tuser <= m;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(m, x, y, z);
    endtask

    task automatic send_random();
        mode_t              m;
        logic signed [23:0] p [3];
        int unsigned        r;
        int unsigned        src;
        int unsigned        spread;
        r = $urandom_range(99);
        m = (r < 30) ? MODE_FIND : (r < 60) ? MODE_ADD_MISS :
            (r < 85) ? MODE_ADD_ALWAYS : MODE_UNUSED;
        if (sb.point_total > 0 && $urandom_range(99) < 55) begin
            src = $urandom_range(sb.point_total - 1);
            spread = pick_spread(sb.match_limit);
            for (int k = 0; k < 3; k++)
                p[k] = clamp_coord(longint'(sb.stored[src][k]) +
                                   longint'($urandom_range(2 * spread)) - longint'(spread));
        end else begin
            for (int k = 0; k < 3; k++)
                p[k] = rand_coord();
        end
        send_point(m, p[0], p[1], p[2]);
    endtask

    // hold off until every request has its result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic check_threshold_reg(logic [22:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= REG_THRESHOLD_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== {9'd0, want})
            sb.report($sformatf("threshold readback got %0h want %0h", prdata, want));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_threshold(logic [31:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_THRESHOLD_ADDR;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        sb.set_threshold(value[22:0]);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        check_threshold_reg(value[22:0]);
    endtask

    initial begin
        logic [22:0] phase_thr [5];
        logic [31:0] w;
        sb = new();
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= MODE_FIND;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_threshold_reg('0);

        // directed: empty table, extremes, exact and boundary distances, ties
        write_threshold(32'd512);
        send_point(MODE_FIND, 0, 0, 0);
        send_point(MODE_UNUSED, 5, 5, 5);
        send_point(MODE_ADD_MISS, 100, 200, 300);
        send_point(MODE_ADD_ALWAYS, C_MAX, C_MAX, C_MAX);
        send_point(MODE_ADD_ALWAYS, C_MIN, C_MIN, C_MIN);
        send_point(MODE_FIND, 100, 200, 300);
        send_point(MODE_FIND, 400, 200, 300);
        send_point(MODE_FIND, 612, 200, 300);
        send_point(MODE_ADD_MISS, 612, 200, 300);
        send_point(MODE_ADD_MISS, 611, 200, 300);
        send_point(MODE_ADD_ALWAYS, 100, 200, 300);
        send_point(MODE_FIND, 100, 200, 300);
        send_point(MODE_UNUSED, C_MAX, C_MAX, C_MAX);
        send_point(MODE_FIND, C_MIN, C_MIN + 24'sd1, C_MIN);
        send_point(MODE_ADD_ALWAYS, -1, -1, -1);
        send_point(MODE_ADD_ALWAYS, 0, 0, 0);
        write_threshold({9'd0, THRESH_TOP});
        send_point(MODE_FIND, C_MAX, C_MIN, C_MAX);
        send_point(MODE_ADD_MISS, 1000, -1000, 0);
        write_threshold(32'd0);
        send_point(MODE_FIND, 100, 200, 300);
        send_point(MODE_ADD_MISS, 100, 200, 300);

        // random phases, each under its own threshold
        phase_thr[0] = 23'd256;
        phase_thr[1] = 23'd0;
        phase_thr[2] = 23'($urandom_range(20000, 1));
        phase_thr[3] = THRESH_TOP;
        phase_thr[4] = 23'd2048;
        for (int ph = 0; ph < 5; ph++) begin
            w = $urandom();
            if (ph == 4)
                write_threshold((w & 32'hFF80_0000) | {9'd0, phase_thr[ph]});
            else
                write_threshold({9'd0, phase_thr[ph]});
            no_idle = (ph == 3);
            for (int n = 0; n < 84; n++) begin
                if (ph == 0 && n == 42)
                    drain();
                send_random();
            end
        end
        no_idle = 1'b0;

        write_threshold({9'd0, THRESH_TOP});
        for (int n = 0; n < 8; n++)
            send_random();
        send_point(MODE_ADD_MISS, C_MAX, C_MIN, C_MAX);
        send_point(MODE_ADD_ALWAYS, C_MIN, C_MAX, C_MIN);

        drain();
        repeat (16) @(posedge aclk);
        if (sb.awaited_results.size() != 0)
            sb.report("requests left without a result");
        $display("ran %0d requests through directed and random threshold phases,",
                 sb.n_req);
        $display("%0d matched, %0d appended, %0d refused, %0d points stored",
                 sb.n_found, sb.n_added, sb.n_full, sb.point_total);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/vwt_pkg.sv
rtl/vertex_weld_table_unit.sv
tb/sv/vertex_weld_table_unit_test.sv
